// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg: shared types and codes of the levelized topological sort
// Field widths, item codes and the result record passed to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
package lts_pkg;

  localparam int NODE_W = 6;
  localparam int LVL_W  = 6;
  localparam int KIND_W = 2;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;
  localparam int DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LINK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TRAV  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [KIND_W-1:0] KIND_INPUT = 2'd1;

  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_REJECT = 2'd1;
  localparam logic [STS_W-1:0] STS_CYCLE  = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [LVL_W-1:0]  level;
    logic [KIND_W-1:0] kind;
    logic [STS_W-1:0]  status;
    logic              last;
  } lts_res_t;

endpackage
`default_nettype wire

// ===== rtl/lts_out_buf.sv =====
// ----------------------------------------------------------------------------
// lts_out_buf: result holding register
// Keeps one finished result item on the output channel until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module lts_out_buf
  import lts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lts_res_t          res,
  output logic                   ready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // node_id_out [5:0], level [11:6], type_out [13:12], zero [15:14]
  output logic [DATA_W-1:0]      out_tdata,
  // status [1:0]
  output logic [STS_W-1:0]       out_tuser,
  output logic                   out_tlast
);

  logic     valid_r;
  lts_res_t hold_r;

  assign ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= push;
    end
    if (push && ready) begin
      hold_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, hold_r.kind, hold_r.level, hold_r.node_id};
  assign out_tuser  = hold_r.status;
  assign out_tlast  = hold_r.last;

endmodule
`default_nettype wire

// ===== rtl/levelized_topological_sort.sv =====
// ----------------------------------------------------------------------------
// levelized_topological_sort: Kahn sort of a small graph, level by level
// Loads nodes and links, then emits every reachable node with its level.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An add or clear item passes from idle
// to the emit state, and a link item through the link state first unless one
// of its nodes is undeclared; each may wait there for the output register to
// drain, and its result is one item with tlast set. A traverse item first
// clears the arrival counters in a pass over all MAX_NODES of them, then reads
// the declaration list, going through the seed states per declared node. For
// every node taken from the ready queue it fetches the node in the dequeue
// states, then walks every stored edge, with a write-back step for an edge
// that leaves that node (the read-modify-write of the arrival counter), then
// sweeps all MAX_NODES end nodes, with an extra read for a node that was hit,
// and emits the node through its emit states. Results leave level by level;
// the final one carries tlast, and status 2 when some declared node was
// never reached, which points at a cycle in the graph.
`default_nettype none
module levelized_topological_sort
  import lts_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // node_id [5:0], end_node [11:6], node_type [13:12], zero [15:14]
  input  wire logic [DATA_W-1:0] in_tdata,
  // op [1:0]
  input  wire logic [OP_W-1:0]   in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // node_id_out [5:0], level [11:6], type_out [13:12], zero [15:14]
  output logic [DATA_W-1:0]      out_tdata,
  // status [1:0]
  output logic [STS_W-1:0]       out_tuser,
  output logic                   out_tlast
);

  localparam int NIDX = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EIDX = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int NMW  = KIND_W + ECW;
  localparam logic [NODE_W:0]   MAXN_C = (NODE_W+1)'(MAX_NODES);
  localparam logic [NCW-1:0]    DECL_MAX = NCW'(MAX_NODES);
  localparam logic [ECW-1:0]    EDGE_MAX = ECW'(MAX_EDGES);
  localparam logic [NIDX-1:0]   LASTN = NIDX'(MAX_NODES - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_EMIT    = 5'd1;
  localparam logic [4:0] S_LINK    = 5'd2;
  localparam logic [4:0] S_CLR     = 5'd3;
  localparam logic [4:0] S_SEED    = 5'd4;
  localparam logic [4:0] S_SEED2   = 5'd5;
  localparam logic [4:0] S_SEED3   = 5'd6;
  localparam logic [4:0] S_SDONE   = 5'd7;
  localparam logic [4:0] S_DEQ     = 5'd8;
  localparam logic [4:0] S_DEQ2    = 5'd9;
  localparam logic [4:0] S_EREAD   = 5'd10;
  localparam logic [4:0] S_EDAT    = 5'd11;
  localparam logic [4:0] S_AWR     = 5'd12;
  localparam logic [4:0] S_SWP     = 5'd13;
  localparam logic [4:0] S_SWP2    = 5'd14;
  localparam logic [4:0] S_EMITN   = 5'd15;
  localparam logic [4:0] S_EMITN2  = 5'd16;

  // Node memory holds {kind, in-degree}; edge memory holds {from, to}.
  logic [NMW-1:0]    node_mem  [MAX_NODES];
  logic [2*NIDX-1:0] edge_mem  [MAX_EDGES];
  logic [ECW-1:0]    arr_mem   [MAX_NODES];
  logic [NIDX-1:0]   order_mem [MAX_NODES];
  logic [NIDX-1:0]   queue_mem [MAX_NODES];

  logic [NMW-1:0]    nm_rd_r;
  logic [2*NIDX-1:0] ed_rd_r;
  logic [ECW-1:0]    ar_rd_r;
  logic [NIDX-1:0]   io_rd_r, rq_rd_r;

  logic              nm_we, ed_we, ar_we, io_we, rq_we;
  logic [NIDX-1:0]   nm_wa, nm_ra, ar_wa, ar_ra, io_wa, io_ra, rq_wa, rq_ra;
  logic [EIDX-1:0]   ed_wa, ed_ra;
  logic [NMW-1:0]    nm_wd;
  logic [2*NIDX-1:0] ed_wd;
  logic [ECW-1:0]    ar_wd;
  logic [NIDX-1:0]   io_wd, rq_wd;

  logic [4:0]           state_r, state_nxt, ret_r, ret_nxt;
  logic [MAX_NODES-1:0] valid_r, valid_nxt, touched_r, touched_nxt;
  logic [NCW-1:0]       decl_r, decl_nxt, cnt_r, cnt_nxt;
  logic [NCW-1:0]       qn_r, qn_nxt, head_r, head_nxt, lend_r, lend_nxt;
  logic [ECW-1:0]       etot_r, etot_nxt, j_r, j_nxt;
  logic [NODE_W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [NIDX-1:0]      n_r, n_nxt, to_r, to_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  lts_res_t             res_r, res_nxt;

  logic              push, ob_ready, in_acc, last_w;
  logic [NODE_W-1:0] in_a, in_b;
  logic [KIND_W-1:0] in_t;
  logic              a_oor, b_oor;
  logic [NIDX-1:0]   ea_idx, eb_idx, sw_idx, ed_from, ed_to;

  function automatic lts_res_t status_res(input logic [STS_W-1:0] s);
    lts_res_t r;
    r = '0;
    r.status = s;
    r.last   = 1'b1;
    return r;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_a      = in_tdata[NODE_W-1:0];
  assign in_b      = in_tdata[2*NODE_W-1:NODE_W];
  assign in_t      = in_tdata[2*NODE_W+KIND_W-1:2*NODE_W];
  assign a_oor     = {1'b0, in_a} >= MAXN_C;
  assign b_oor     = {1'b0, in_b} >= MAXN_C;
  assign ea_idx    = in_a[NIDX-1:0];
  assign eb_idx    = in_b[NIDX-1:0];
  assign sw_idx    = cnt_r[NIDX-1:0];
  assign ed_from   = ed_rd_r[2*NIDX-1:NIDX];
  assign ed_to     = ed_rd_r[NIDX-1:0];
  assign last_w    = (head_r == qn_r);

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;     valid_nxt = valid_r;
    touched_nxt = touched_r; decl_nxt = decl_r; cnt_nxt = cnt_r;
    qn_nxt = qn_r;         head_nxt = head_r;   lend_nxt = lend_r;
    etot_nxt = etot_r;     j_nxt = j_r;         a_nxt = a_r;
    b_nxt = b_r;           n_nxt = n_r;         to_nxt = to_r;
    lvl_nxt = lvl_r;       res_nxt = res_r;     push = 1'b0;
    nm_we = 1'b0; ed_we = 1'b0; ar_we = 1'b0; io_we = 1'b0; rq_we = 1'b0;
    nm_wa = eb_idx; nm_wd = '0; nm_ra = n_r;
    ed_wa = etot_r[EIDX-1:0]; ed_wd = {a_r[NIDX-1:0], b_r[NIDX-1:0]};
    ed_ra = j_r[EIDX-1:0];
    ar_wa = to_r; ar_wd = ar_rd_r + ECW'(1); ar_ra = to_r;
    io_wa = decl_r[NIDX-1:0]; io_wd = ea_idx; io_ra = sw_idx;
    rq_wa = qn_r[NIDX-1:0]; rq_wd = n_r; rq_ra = head_r[NIDX-1:0];

    unique case (state_r) inside
      S_IDLE: begin
        if (in_acc) begin
          a_nxt = in_a;
          b_nxt = in_b;
          unique case (in_tuser)
            OP_ADD: begin
              res_nxt = status_res(a_oor ? STS_REJECT : STS_OK);
              if (!a_oor && !valid_r[ea_idx] && decl_r < DECL_MAX) begin
                valid_nxt[ea_idx] = 1'b1;
                nm_we = 1'b1;
                nm_wa = ea_idx;
                nm_wd = {in_t, ECW'(0)};
                io_we = 1'b1;
                decl_nxt = decl_r + NCW'(1);
              end
              ret_nxt = S_IDLE;
              state_nxt = S_EMIT;
            end
            OP_LINK: begin
              if (a_oor || b_oor || !valid_r[ea_idx] || !valid_r[eb_idx]) begin
                res_nxt = status_res(STS_REJECT);
                ret_nxt = S_IDLE;
                state_nxt = S_EMIT;
              end else begin
                nm_ra = eb_idx;
                state_nxt = S_LINK;
              end
            end
            OP_TRAV: begin
              cnt_nxt = '0;
              state_nxt = S_CLR;
            end
            default: begin
              valid_nxt = '0;
              decl_nxt = '0;
              etot_nxt = '0;
              qn_nxt = '0;
              head_nxt = '0;
              res_nxt = status_res(STS_OK);
              ret_nxt = S_IDLE;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_LINK: begin
        ret_nxt = S_IDLE;
        state_nxt = S_EMIT;
        if (nm_rd_r[NMW-1:ECW] == KIND_INPUT) begin
          res_nxt = status_res(STS_REJECT);
        end else if (etot_r >= EDGE_MAX) begin
          res_nxt = status_res(STS_FULL);
        end else begin
          res_nxt = status_res(STS_OK);
          ed_we = 1'b1;
          etot_nxt = etot_r + ECW'(1);
          nm_we = 1'b1;
          nm_wa = b_r[NIDX-1:0];
          nm_wd = {nm_rd_r[NMW-1:ECW], nm_rd_r[ECW-1:0] + ECW'(1)};
        end
      end
      S_EMIT: begin
        if (ob_ready) begin
          push = 1'b1;
          state_nxt = ret_r;
        end
      end
      S_CLR: begin
        ar_we = 1'b1;
        ar_wa = sw_idx;
        ar_wd = '0;
        if (sw_idx == LASTN) begin
          cnt_nxt = '0;
          qn_nxt = '0;
          head_nxt = '0;
          state_nxt = S_SEED;
        end else begin
          cnt_nxt = cnt_r + NCW'(1);
        end
      end
      S_SEED: begin
        state_nxt = (cnt_r < decl_r) ? S_SEED2 : S_SDONE;
      end
      S_SEED2: begin
        n_nxt = io_rd_r;
        nm_ra = io_rd_r;
        state_nxt = S_SEED3;
      end
      S_SEED3: begin
        if (nm_rd_r[NMW-1:ECW] == KIND_INPUT) begin
          rq_we = 1'b1;
          qn_nxt = qn_r + NCW'(1);
        end
        cnt_nxt = cnt_r + NCW'(1);
        state_nxt = S_SEED;
      end
      S_SDONE: begin
        lend_nxt = qn_r;
        head_nxt = '0;
        lvl_nxt = '0;
        if (qn_r == '0) begin
          res_nxt = status_res((decl_r != '0) ? STS_CYCLE : STS_OK);
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DEQ;
        end
      end
      S_DEQ: begin
        state_nxt = S_DEQ2;
      end
      S_DEQ2: begin
        n_nxt = rq_rd_r;
        if (head_r == lend_r) begin
          lvl_nxt = lvl_r + LVL_W'(1);
          lend_nxt = qn_r;
        end
        head_nxt = head_r + NCW'(1);
        touched_nxt = '0;
        j_nxt = '0;
        state_nxt = S_EREAD;
      end
      S_EREAD: begin
        if (j_r < etot_r) begin
          state_nxt = S_EDAT;
        end else begin
          cnt_nxt = '0;
          state_nxt = S_SWP;
        end
      end
      S_EDAT: begin
        if (ed_from == n_r) begin
          touched_nxt[ed_to] = 1'b1;
          ar_ra = ed_to;
          to_nxt = ed_to;
          state_nxt = S_AWR;
        end else begin
          j_nxt = j_r + ECW'(1);
          state_nxt = S_EREAD;
        end
      end
      S_AWR: begin
        ar_we = 1'b1;
        j_nxt = j_r + ECW'(1);
        state_nxt = S_EREAD;
      end
      S_SWP, S_SWP2: begin
        if (state_r == S_SWP && touched_r[sw_idx]) begin
          ar_ra = sw_idx;
          nm_ra = sw_idx;
          state_nxt = S_SWP2;
        end else begin
          if (state_r == S_SWP2 && ar_rd_r == nm_rd_r[ECW-1:0]) begin
            rq_we = 1'b1;
            rq_wd = sw_idx;
            qn_nxt = qn_r + NCW'(1);
          end
          if (sw_idx == LASTN) begin
            state_nxt = S_EMITN;
          end else begin
            cnt_nxt = cnt_r + NCW'(1);
            state_nxt = S_SWP;
          end
        end
      end
      S_EMITN: begin
        state_nxt = S_EMITN2;
      end
      S_EMITN2: begin
        res_nxt.node_id = NODE_W'(n_r);
        res_nxt.level   = lvl_r;
        res_nxt.kind    = nm_rd_r[NMW-1:ECW];
        res_nxt.last    = last_w;
        res_nxt.status  = (last_w && qn_r < decl_r) ? STS_CYCLE : STS_OK;
        ret_nxt = last_w ? S_IDLE : S_DEQ;
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      valid_r <= '0;
      decl_r  <= '0;
      etot_r  <= '0;
      qn_r    <= '0;
      head_r  <= '0;
      lend_r  <= '0;
      cnt_r   <= '0;
      j_r     <= '0;
      touched_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      valid_r <= valid_nxt;
      decl_r  <= decl_nxt;
      etot_r  <= etot_nxt;
      qn_r    <= qn_nxt;
      head_r  <= head_nxt;
      lend_r  <= lend_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
      touched_r <= touched_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    to_r  <= to_nxt;
    lvl_r <= lvl_nxt;
    res_r <= res_nxt;
  end

  // Synchronous memories: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    nm_rd_r <= node_mem[nm_ra];
    if (ed_we) edge_mem[ed_wa] <= ed_wd;
    ed_rd_r <= edge_mem[ed_ra];
    if (ar_we) arr_mem[ar_wa] <= ar_wd;
    ar_rd_r <= arr_mem[ar_ra];
    if (io_we) order_mem[io_wa] <= io_wd;
    io_rd_r <= order_mem[io_ra];
    if (rq_we) queue_mem[rq_wa] <= rq_wd;
    rq_rd_r <= queue_mem[rq_ra];
  end

  lts_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res        (res_r),
    .ready      (ob_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_head_le_qn: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= qn_r) else $error("queue head passed the tail");
  a_qn_le_decl: assert property (@(posedge clk) disable iff (!rst_n)
    qn_r <= decl_r) else $error("more nodes queued than declared");
  a_etot_max: assert property (@(posedge clk) disable iff (!rst_n)
    etot_r <= EDGE_MAX) else $error("edge count beyond edge memory");
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ob_ready) else $error("result pushed into a full output register");
  a_awr_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWR) |-> touched_r[to_r]) else $error("arrival update on untouched node");

endmodule
`default_nettype wire

// ===== tb/lts_checker.sv =====
// ----------------------------------------------------------------------------
// lts_checker: result predictor and scoreboard of the levelized sort
// Watches both streams, keeps its own copy of the graph store, works out the
// results of every accepted item and compares them with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module lts_checker
  import lts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic [OP_W-1:0]   in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,
  input  logic [STS_W-1:0]  out_tuser,
  input  logic              out_tlast,
  output int                errors,
  output int                pending,
  output int                results_seen
);

  localparam int NODES = 64;
  localparam int EDGES = 256;

  // Shadow copy of the graph store.
  logic              declared [NODES];
  logic [KIND_W-1:0] kind_of  [NODES];
  logic [8:0]        indeg    [NODES];
  logic [NODE_W-1:0] link_src [EDGES];
  logic [NODE_W-1:0] link_dst [EDGES];
  int                link_cnt;
  logic [NODE_W-1:0] decl_list [NODES];
  int                decl_cnt;

  lts_res_t sort_results [$];

  function automatic lts_res_t status_item(logic [STS_W-1:0] sts);
    lts_res_t r;
    r = '0;
    r.status = sts;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic queue_result(lts_res_t r);
    sort_results = {sort_results, r};
  endtask

  // Kahn sort in levels: each emitted node walks its edges by ascending end.
  task automatic sort_graph();
    logic [8:0]        arrived [NODES];
    logic [NODE_W-1:0] ready_q [NODES];
    int qn, head, lvl, lvl_end, n, k;
    lts_res_t r;
    qn = 0; head = 0; lvl = 0; k = 0;
    for (int i = 0; i < NODES; i++) arrived[i] = '0;
    for (int i = 0; i < decl_cnt; i++) begin
      n = decl_list[i];
      if (declared[n] && kind_of[n] == KIND_INPUT && qn < NODES) begin
        ready_q[qn] = n[NODE_W-1:0];
        qn++;
      end
    end
    lvl_end = qn;
    while (head < qn) begin
      if (head == lvl_end) begin
        lvl++;
        lvl_end = qn;
      end
      n = ready_q[head];
      head++;
      for (int e = 0; e < NODES; e++)
        for (int j = 0; j < link_cnt; j++)
          if (link_src[j] == n && link_dst[j] == e) begin
            arrived[e]++;
            if (arrived[e] == indeg[e] && qn < NODES) begin
              ready_q[qn] = e[NODE_W-1:0];
              qn++;
            end
          end
      r = '0;
      r.node_id = n[NODE_W-1:0];
      r.level   = lvl[LVL_W-1:0];
      r.kind    = kind_of[n];
      queue_result(r);
      k++;
    end
    if (k == 0) begin
      queue_result(status_item(decl_cnt > 0 ? STS_CYCLE : STS_OK));
    end else begin
      r = sort_results.pop_back();
      r.status = (k < decl_cnt) ? STS_CYCLE : STS_OK;
      r.last   = 1'b1;
      queue_result(r);
    end
  endtask

  task automatic predict(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                         logic [NODE_W-1:0] b, logic [KIND_W-1:0] t);
    case (op)
      OP_ADD: begin
        if (!declared[a] && decl_cnt < NODES) begin
          declared[a] = 1'b1;
          kind_of[a]  = t;
          decl_list[decl_cnt] = a;
          decl_cnt++;
        end
        queue_result(status_item(STS_OK));
      end
      OP_LINK: begin
        if (!declared[a] || !declared[b] || kind_of[b] == KIND_INPUT) begin
          queue_result(status_item(STS_REJECT));
        end else if (link_cnt >= EDGES) begin
          queue_result(status_item(STS_FULL));
        end else begin
          link_src[link_cnt] = a;
          link_dst[link_cnt] = b;
          link_cnt++;
          indeg[b]++;
          queue_result(status_item(STS_OK));
        end
      end
      OP_TRAV: sort_graph();
      default: begin
        for (int i = 0; i < NODES; i++) begin
          declared[i] = 1'b0;
          indeg[i]    = '0;
        end
        link_cnt = 0;
        decl_cnt = 0;
        queue_result(status_item(STS_OK));
      end
    endcase
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    link_cnt = 0;
    decl_cnt = 0;
    for (int i = 0; i < NODES; i++) begin
      declared[i] = 1'b0;
      indeg[i]    = '0;
    end
  end

  always @(posedge clk) begin
    lts_res_t want, got;
    if (rst_n) begin
      // Compare first: a result never belongs to an item taken at this edge.
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.node_id = out_tdata[5:0];
        got.level   = out_tdata[11:6];
        got.kind    = out_tdata[13:12];
        got.status  = out_tuser;
        got.last    = out_tlast;
        if (sort_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result id=%0d lvl=%0d kind=%0d sts=%0d last=%0d",
                   $time, got.node_id, got.level, got.kind, got.status, got.last);
        end else begin
          want = sort_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected id=%0d lvl=%0d kind=%0d sts=%0d last=%0d,",
                     $time, want.node_id, want.level, want.kind, want.status,
                     want.last);
            $display("%0t: got      id=%0d lvl=%0d kind=%0d sts=%0d last=%0d",
                     $time, got.node_id, got.level, got.kind, got.status,
                     got.last);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[13:12]);
    end
    pending = sort_results.size();
  end

endmodule

// ===== tb/levelized_topological_sort_tb.sv =====
// ----------------------------------------------------------------------------
// levelized_topological_sort_tb: stimulus and verdict for the graph sorter
// Drives directed and random graph loads and traversals with random gaps on
// both streams; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module levelized_topological_sort_tb;
  import lts_pkg::*;

  // Cycles without a transfer on either stream before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic [OP_W-1:0]   in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic [STS_W-1:0]  out_tuser;
  logic              out_tlast;

  int errors, pending, results_seen;
  int items_sent;
  int idle_cycles;
  bit hold_request;

  // Node ids declared since the last clear, so that random links mostly
  // join real nodes and the traversal has something to walk.
  logic [NODE_W-1:0] known_ids [$];

  levelized_topological_sort DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  lts_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Offer one item after a random gap and hold it until it is taken. With a
  // zero gap valid simply stays high across back-to-back items.
  task automatic send_item(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                           logic [NODE_W-1:0] b, logic [KIND_W-1:0] t);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, t, b, a};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_CLEAR) known_ids.delete();
    if (op == OP_ADD) known_ids = {known_ids, a};
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if (known_ids.size() == 0 || $urandom_range(0, 9) == 0)
      return NODE_W'($urandom_range(0, 63));
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  // Receiver: a random stall before each result, and one long hold-off on
  // request so the output register backs up and the input stalls.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on progress of either stream.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("levelized_topological_sort_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_add, n_link;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_ADD;
    items_sent   = 0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty sort, duplicate add, every rejection, a self-loop,
    // a duplicate link and a small triangle.
    send_item(OP_TRAV, 0, 0, 0);            // nothing declared: status ok
    send_item(OP_ADD, 0, 0, 0);
    send_item(OP_ADD, 63, 0, 1);            // input node at the top id
    send_item(OP_ADD, 63, 0, 3);            // already declared: keeps its type
    send_item(OP_TRAV, 0, 0, 0);            // node 0 unreached
    send_item(OP_LINK, 63, 0, 0);
    send_item(OP_LINK, 0, 63, 0);           // ends on an input node
    send_item(OP_LINK, 5, 0, 0);            // undeclared start
    send_item(OP_LINK, 0, 42, 0);           // undeclared end
    send_item(OP_ADD, 1, 63, 2);
    send_item(OP_ADD, 2, 21, 3);
    send_item(OP_LINK, 63, 1, 3);
    send_item(OP_LINK, 1, 2, 0);
    send_item(OP_LINK, 63, 2, 0);
    send_item(OP_LINK, 63, 2, 0);           // duplicate link is stored
    send_item(OP_TRAV, 0, 0, 0);
    send_item(OP_ADD, 7, 0, 0);
    send_item(OP_LINK, 7, 7, 0);            // self-loop: node 7 never reached
    send_item(OP_TRAV, 63, 63, 3);
    send_item(OP_TRAV, 0, 0, 0);            // repeat of the sort: node 7 still unreached
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_TRAV, 0, 0, 0);

    // Long chain over 24 ids reaches level 23. The receiver holds off while
    // the first adds pour in.
    hold_request = 1'b1;
    send_item(OP_ADD, 0, 0, 1);
    for (int i = 1; i < 24; i++)
      send_item(OP_ADD, NODE_W'(i), 0, KIND_W'((i % 4 == 1) ? 2 : i % 4));
    for (int i = 0; i < 23; i++) send_item(OP_LINK, NODE_W'(i), NODE_W'(i + 1), 0);
    send_item(OP_TRAV, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0);

    // Random graphs: mostly well-formed loads followed by a sort, with noise.
    for (int g = 0; g < 10; g++) begin
      if ($urandom_range(0, 2) == 0)
        send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom), KIND_W'($urandom));
      n_add = $urandom_range(1, 6);
      for (int i = 0; i < n_add; i++)
        send_item(OP_ADD, NODE_W'($urandom_range(0, 63)), NODE_W'($urandom),
                  ($urandom_range(0, 2) == 0) ? KIND_INPUT
                                              : KIND_W'($urandom_range(0, 3)));
      n_link = $urandom_range(0, 8);
      for (int i = 0; i < n_link; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_W'($urandom_range(0, 3)), NODE_W'($urandom),
                    NODE_W'($urandom), KIND_W'($urandom));
        else
          send_item(OP_LINK, pick_node(), pick_node(), KIND_W'($urandom));
      end
      send_item(OP_TRAV, NODE_W'($urandom), NODE_W'($urandom), KIND_W'($urandom));
    end

    // Drain, then a margin for any late or extra result.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d items (loads, rejected links, self-loops, sorts, clears);",
             items_sent);
    $display("checked %0d results, including a 24-level chain and a long output stall.",
             results_seen);
    if (errors == 0) begin
      $display("levelized_topological_sort_tb: clean");
    end else begin
      $display("levelized_topological_sort_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lts_pkg.sv
rtl/lts_out_buf.sv
rtl/levelized_topological_sort.sv
tb/lts_checker.sv
tb/levelized_topological_sort_tb.sv
